### rtl/core/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants of the Caesar frequency breaker.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int ACTION_W = 2;
	localparam int CODE_W = 8;
	localparam int LETTER_W = 5;
	localparam int NUM_LETTERS = 26;

	localparam logic [CODE_W-1:0] CODE_A = 8'd65;
	localparam logic [CODE_W-1:0] CODE_Z = 8'd90;
	localparam logic [LETTER_W-1:0] ASSUMED_RESET = 5'd19;

	typedef enum logic [ACTION_W-1:0] {
		ACT_COUNT  = 2'd0,
		ACT_DECODE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef struct packed {
		logic                count_en;
		logic                clear_en;
		logic [LETTER_W-1:0] idx;
	} hist_cmd_t;

	function automatic logic is_upper(input logic [CODE_W-1:0] code);
		return (code >= CODE_A) && (code <= CODE_Z);
	endfunction

endpackage

### rtl/core/cfb_item_if.sv
// ----------------------------------------------------------------------------
// cfb_item_if
// Input item channel: action and ciphertext character code.
// ----------------------------------------------------------------------------
interface cfb_item_if;
	import cfb_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CODE_W-1:0]   letter_code;

	modport source(output valid, action, letter_code, input ready);
	modport sink(input valid, action, letter_code, output ready);
endinterface

### rtl/core/cfb_result_if.sv
// ----------------------------------------------------------------------------
// cfb_result_if
// Result channel: decoded character code and the rotation used.
// ----------------------------------------------------------------------------
interface cfb_result_if;
	import cfb_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   plain_code;
	logic [LETTER_W-1:0] key_shift;

	modport source(output valid, plain_code, key_shift, input ready);
	modport sink(input valid, plain_code, key_shift, output ready);
endinterface

### rtl/core/cfb_cfg_if.sv
// ----------------------------------------------------------------------------
// cfb_cfg_if
// Configuration write channel for the assumed plaintext letter.
// ----------------------------------------------------------------------------
interface cfb_cfg_if;
	import cfb_pkg::*;

	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

### rtl/core/caesar_frequency_breaker_core.sv
// ----------------------------------------------------------------------------
// caesar_frequency_breaker_core
// A decode item passes the input stage register, then the output register, before its result shows.
// Throughput: one item per cycle while results are taken; the output register frees the input stage.
// Reset clears the histogram and top letter and sets the assumed letter to T.
// ----------------------------------------------------------------------------
module caesar_frequency_breaker_core #(
	parameter int COUNT_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	cfb_cfg_if.sink      cfg,
	cfb_item_if.sink     items,
	cfb_result_if.source results
);
	import cfb_pkg::*;

	logic [LETTER_W-1:0] assumed_q;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [CODE_W-1:0]   code_s1;

	logic                out_valid_q;
	logic [CODE_W-1:0]   plain_q;
	logic [LETTER_W-1:0] key_q;

	logic                out_free;
	logic                s1_free;
	logic                load_out;
	hist_cmd_t           hist_cmd;
	logic [LETTER_W-1:0] top_letter;
	logic [CODE_W-1:0]   dec_plain;
	logic [LETTER_W-1:0] dec_key;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assumed_q <= ASSUMED_RESET;
		end else if (cfg.valid) begin
			assumed_q <= cfg.data;
		end
	end

	always_comb begin
		out_free = !out_valid_q || results.ready;
		s1_free = (action_s1 != ACT_DECODE) || out_free;
		load_out = valid_s1 && (action_s1 == ACT_DECODE) && out_free;
		hist_cmd.count_en = valid_s1 && (action_s1 == ACT_COUNT) && is_upper(code_s1);
		hist_cmd.clear_en = valid_s1 && (action_s1 == ACT_CLEAR);
		hist_cmd.idx = LETTER_W'(code_s1 - CODE_A);
	end

	assign items.ready = !valid_s1 || s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			action_s1 <= items.action;
			code_s1 <= items.letter_code;
		end
	end

	cfb_histogram #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_histogram (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (hist_cmd),
		.top_letter(top_letter)
	);

	cfb_decoder u_decoder (
		.top_letter    (top_letter),
		.assumed_letter(assumed_q),
		.letter_code   (code_s1),
		.plain_code    (dec_plain),
		.key_shift     (dec_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			plain_q <= dec_plain;
			key_q <= dec_key;
		end
	end

	assign results.valid = out_valid_q;
	assign results.plain_code = plain_q;
	assign results.key_shift = key_q;

endmodule

### rtl/core/cfb_histogram.sv
// ----------------------------------------------------------------------------
// cfb_histogram
// Saturating letter counters with running most-frequent letter tracking.
// ----------------------------------------------------------------------------
module cfb_histogram #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfb_pkg::hist_cmd_t           cmd,
	output logic [cfb_pkg::LETTER_W-1:0] top_letter
);
	import cfb_pkg::*;

	logic [COUNT_WIDTH-1:0] counts_q [NUM_LETTERS];
	logic [COUNT_WIDTH-1:0] top_count_q;
	logic [LETTER_W-1:0]    top_letter_q;

	logic [COUNT_WIDTH-1:0] cur_count;
	logic [COUNT_WIDTH-1:0] nxt_count;
	logic                   not_sat;
	logic                   take_top;

	always_comb begin
		cur_count = counts_q[cmd.idx];
		nxt_count = cur_count + COUNT_WIDTH'(1);
		not_sat = (cur_count != {COUNT_WIDTH{1'b1}});
		take_top = (nxt_count > top_count_q) ||
			((nxt_count == top_count_q) && (cmd.idx < top_letter_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++) begin
				counts_q[i] <= '0;
			end
			top_count_q <= '0;
			top_letter_q <= '0;
		end else if (cmd.clear_en) begin
			for (int i = 0; i < NUM_LETTERS; i++) begin
				counts_q[i] <= '0;
			end
			top_count_q <= '0;
			top_letter_q <= '0;
		end else if (cmd.count_en && not_sat) begin
			counts_q[cmd.idx] <= nxt_count;
			if (take_top) begin
				top_count_q <= nxt_count;
				top_letter_q <= cmd.idx;
			end
		end
	end

	assign top_letter = top_letter_q;

endmodule

### rtl/core/cfb_decoder.sv
// ----------------------------------------------------------------------------
// cfb_decoder
// Key derivation and mod-26 back rotation of one character.
// ----------------------------------------------------------------------------
module cfb_decoder (
	input  logic [cfb_pkg::LETTER_W-1:0] top_letter,
	input  logic [cfb_pkg::LETTER_W-1:0] assumed_letter,
	input  logic [cfb_pkg::CODE_W-1:0]   letter_code,
	output logic [cfb_pkg::CODE_W-1:0]   plain_code,
	output logic [cfb_pkg::LETTER_W-1:0] key_shift
);
	import cfb_pkg::*;

	localparam logic [LETTER_W:0] NUM_L = (LETTER_W + 1)'(NUM_LETTERS);

	logic [LETTER_W-1:0] assumed_mod;
	logic [LETTER_W:0]   diff;
	logic [LETTER_W-1:0] key;
	logic [LETTER_W-1:0] idx;
	logic [LETTER_W:0]   rot_sum;
	logic [LETTER_W-1:0] rot;

	always_comb begin
		assumed_mod = (assumed_letter >= LETTER_W'(NUM_LETTERS)) ?
			assumed_letter - LETTER_W'(NUM_LETTERS) : assumed_letter;
		diff = {1'b0, top_letter} + NUM_L - {1'b0, assumed_mod};
		key = (diff >= NUM_L) ? LETTER_W'(diff - NUM_L) : LETTER_W'(diff);
		idx = LETTER_W'(letter_code - CODE_A);
		rot_sum = {1'b0, idx} + NUM_L - {1'b0, key};
		rot = (rot_sum >= NUM_L) ? LETTER_W'(rot_sum - NUM_L) : LETTER_W'(rot_sum);
		plain_code = is_upper(letter_code) ? CODE_A + CODE_W'(rot) : letter_code;
		key_shift = key;
	end

endmodule

### rtl/core/cfb_checker.sv
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks of the Caesar frequency breaker over time.
// ----------------------------------------------------------------------------
module cfb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [cfb_pkg::CODE_W-1:0]   res_plain,
	input logic [cfb_pkg::LETTER_W-1:0] res_key
);
	import cfb_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_plain) && $stable(res_key))
		else $error("Stalled result changed or was dropped.");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_key < LETTER_W'(NUM_LETTERS))
		else $error("Key shift out of range.");

	a_res_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready, 2))
		else $error("Result appeared without a matching input transfer.");

endmodule

bind caesar_frequency_breaker_core cfb_checker u_cfb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (items.valid),
	.in_ready (items.ready),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_plain(results.plain_code),
	.res_key  (results.key_shift)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives count, decode, clear and unused transfers into the frequency breaker,
// keeps a running histogram of its own to predict each decoded character and
// rotation, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cfb_pkg::*;

	localparam int CW = 8;
	localparam int SETTLE = 4;
	localparam int QUIET_LIMIT = 500;
	localparam int NROWS = 20;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0]   plain;
		logic [LETTER_W-1:0] key;
	} decode_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [CODE_W-1:0]   code;
		logic                typed;
		logic [CODE_W-1:0]   plain;
		logic [LETTER_W-1:0] key;
	} step_row_t;

	// Rows with typed results hold for the reset setting of T with A on top.
	localparam step_row_t SCRIPT [NROWS] = '{
		'{ACT_DECODE, "A", 1'b1, "T", 5'd7},
		'{ACT_DECODE, "Z", 1'b1, "S", 5'd7},
		'{ACT_DECODE, 8'h00, 1'b1, 8'h00, 5'd7},
		'{ACT_DECODE, 8'hFF, 1'b1, 8'hFF, 5'd7},
		'{ACT_DECODE, "@", 1'b1, "@", 5'd7},
		'{ACT_DECODE, "[", 1'b1, "[", 5'd7},
		'{ACT_DECODE, "a", 1'b1, "a", 5'd7},
		'{ACT_COUNT, "H", 1'b0, 8'h00, 5'd0},
		'{ACT_COUNT, 8'hFF, 1'b0, 8'h00, 5'd0},
		'{ACT_COUNT, "C", 1'b0, 8'h00, 5'd0},
		'{ACT_DECODE, "C", 1'b0, 8'h00, 5'd0},
		'{ACT_UNUSED, "Z", 1'b0, 8'h00, 5'd0},
		'{ACT_COUNT, "Z", 1'b0, 8'h00, 5'd0},
		'{ACT_COUNT, "Z", 1'b0, 8'h00, 5'd0},
		'{ACT_DECODE, "Z", 1'b0, 8'h00, 5'd0},
		'{ACT_CLEAR, 8'h5A, 1'b0, 8'h00, 5'd0},
		'{ACT_DECODE, "A", 1'b1, "T", 5'd7},
		'{ACT_UNUSED, 8'hFF, 1'b0, 8'h00, 5'd0},
		'{ACT_COUNT, "A", 1'b0, 8'h00, 5'd0},
		'{ACT_DECODE, "M", 1'b0, 8'h00, 5'd0}
	};

	logic clk;
	logic arst_n;

	cfb_cfg_if    cfg_bus();
	cfb_item_if   item_bus();
	cfb_result_if res_bus();

	caesar_frequency_breaker_core #(
		.COUNT_WIDTH(CW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.items(item_bus),
		.results(res_bus)
	);

	logic [CW-1:0]       hist [NUM_LETTERS];
	logic [CW-1:0]       peak_count;
	logic [LETTER_W-1:0] peak_letter;
	logic [LETTER_W-1:0] assumed;
	decode_t             decodes_due [$];
	int                  mismatches;
	int                  quiet;
	bit                  steady;
	logic                fixed_due;
	logic [CODE_W-1:0]   fixed_plain;
	logic [LETTER_W-1:0] fixed_key;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic bit predict_item(input logic [ACTION_W-1:0] act,
			input logic [CODE_W-1:0] code, output decode_t due);
		int idx;
		int k;
		due = '0;
		case (act)
			ACT_COUNT: begin
				if (code >= CODE_A && code <= CODE_Z) begin
					idx = int'(code) - int'(CODE_A);
					if (hist[idx] != {CW{1'b1}}) begin
						hist[idx] = hist[idx] + 1'b1;
						if (hist[idx] > peak_count ||
								(hist[idx] == peak_count && idx < int'(peak_letter))) begin
							peak_count = hist[idx];
							peak_letter = LETTER_W'(idx);
						end
					end
				end
				return 1'b0;
			end
			ACT_CLEAR: begin
				foreach (hist[i])
					hist[i] = '0;
				peak_count = '0;
				peak_letter = '0;
				return 1'b0;
			end
			ACT_DECODE: begin
				k = (int'(peak_letter) + 2 * NUM_LETTERS - int'(assumed)) % NUM_LETTERS;
				due.key = LETTER_W'(k);
				due.plain = code;
				if (code >= CODE_A && code <= CODE_Z)
					due.plain = CODE_W'(int'(CODE_A) +
						(int'(code) - int'(CODE_A) + NUM_LETTERS - k) % NUM_LETTERS);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch on %s, got %0d, want %0d, at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		decode_t due;
		decode_t seen;
		if (!arst_n) begin
			foreach (hist[i])
				hist[i] = '0;
			peak_count = '0;
			peak_letter = '0;
			assumed = ASSUMED_RESET;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				seen.plain = res_bus.plain_code;
				seen.key = res_bus.key_shift;
				if (decodes_due.size() == 0) begin
					report_mismatch("unexpected result", seen.plain, -1);
				end else begin
					due = decodes_due.pop_front();
					if (seen.plain !== due.plain)
						report_mismatch("plain_code", seen.plain, due.plain);
					if (seen.key !== due.key)
						report_mismatch("key_shift", seen.key, due.key);
				end
			end
			if (cfg_bus.valid && cfg_bus.ready)
				assumed = cfg_bus.data;
			if (item_bus.valid && item_bus.ready) begin
				if (predict_item(item_bus.action, item_bus.letter_code, due)) begin
					if (fixed_due) begin
						due.plain = fixed_plain;
						due.key = fixed_key;
					end
					decodes_due.push_back(due);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) ||
				(res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int gap;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				res_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!(res_bus.valid && res_bus.ready))
				@(posedge clk);
		end
	end

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CODE_W-1:0] code,
			input logic typed = 1'b0, input logic [CODE_W-1:0] plain = '0,
			input logic [LETTER_W-1:0] key = '0);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.action <= act;
		item_bus.letter_code <= code;
		fixed_due <= typed;
		fixed_plain <= plain;
		fixed_key <= key;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (decodes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_assumed(input logic [LETTER_W-1:0] value);
		drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [CODE_W-1:0] text_char(input int favorite);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return CODE_W'(int'(CODE_A) + favorite);
		if (roll < 80)
			return CODE_W'(int'(CODE_A) + $urandom_range(0, NUM_LETTERS - 1));
		if (roll < 90)
			return CODE_W'($urandom_range(97, 122));
		return CODE_W'($urandom);
	endfunction

	task automatic run_text(input int n);
		int favorite;
		int roll;
		favorite = $urandom_range(0, NUM_LETTERS - 1);
		send_item(ACT_CLEAR, CODE_W'($urandom));
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_item(ACTION_W'($urandom_range(0, 3)), CODE_W'($urandom));
			else if (roll < 70)
				send_item(ACT_COUNT, text_char(favorite));
			else
				send_item(ACT_DECODE, text_char(favorite));
		end
	endtask

	task automatic saturate_letter(input int letter);
		for (int i = 0; i < 260; i++) begin
			send_item(ACT_COUNT, CODE_W'(int'(CODE_A) + letter));
			if (i % 50 == 49 || (i >= 252 && i <= 256))
				send_item(ACT_DECODE, CODE_W'(int'(CODE_A) + $urandom_range(0, 25)));
		end
	endtask

	initial begin
		logic [LETTER_W-1:0] settings [5];
		settings = '{5'd0, 5'd31, 5'd25, 5'd26, 5'd19};
		mismatches = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.action <= ACT_COUNT;
		item_bus.letter_code <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		fixed_due <= 1'b0;
		fixed_plain <= '0;
		fixed_key <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[r])
			send_item(SCRIPT[r].act, SCRIPT[r].code, SCRIPT[r].typed,
				SCRIPT[r].plain, SCRIPT[r].key);

		for (int p = 0; p < 5; p++) begin
			write_assumed(settings[p]);
			steady = ($urandom_range(0, 3) == 0);
			run_text(40);
		end

		write_assumed(LETTER_W'($urandom_range(0, 31)));
		steady = ($urandom_range(0, 1) == 0);
		send_item(ACT_CLEAR, CODE_W'($urandom));
		saturate_letter(25);
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
